/* rtl/core/lkvc_pkg.sv */
// lkvc_pkg: shared constants and item types for the lru key-value cache
`timescale 1ns / 1ps
package lkvc_pkg;

  // number of entries in the store
  localparam int ENTRIES = 16;
  // entry index, recency rank and fill count widths
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // fixed field widths
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // input item
  typedef struct packed {
    logic               req_type;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lkvc_req_t;

  // result item
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } lkvc_rsp_t;

endpackage

/* rtl/core/lru_key_value_cache.sv */
// lru_key_value_cache: fully associative key-value store with lru replacement
`timescale 1ns / 1ps
//
// Usage
// - input channel: an item (get or put, key, value) is taken on a rising edge
//   where start is high and busy is low. busy is high during reset and until the
//   first edge after it, then stays low, so one item can be taken every cycle.
// - result channel: every item gives one result (hit flag, read value) shown
//   for exactly one cycle with out_valid high. The receiver cannot stall.
// - pipeline: the item is registered in the input register, then looked up and
//   the store updated in one pass; its result is registered in the result
//   register and shown from there.
// - throughput: one item per cycle once busy is low, set by the parallel key
//   compare and rank update across all 16 entries.
// - configuration: cfg_data sets the capacity (0 acts as 1, above 16 acts as
//   16). cfg_ready is always high; write only while the block is idle.
// - reset (synchronous, rst_n low): the store empties, capacity returns to 16
//   and any item in flight is dropped.
//
module lru_key_value_cache (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     start,
  output logic                     busy,
  input  lkvc_pkg::lkvc_req_t      in_req,
  // result channel
  output logic                     out_valid,
  output lkvc_pkg::lkvc_rsp_t      out_rsp,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);
  import lkvc_pkg::*;

  // input register
  logic       s1_valid_r;
  lkvc_req_t  s1_req_r;
  logic       busy_r;

  // store state
  logic [KEY_W-1:0]   key_r   [ENTRIES];
  logic [VALUE_W-1:0] value_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [RANK_W-1:0]  rank_r  [ENTRIES];
  logic [RANK_W-1:0]  rank_nxt[ENTRIES];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CAP_W-1:0]   capacity_r;

  // result register
  logic       out_valid_r;
  lkvc_rsp_t  out_rsp_r, out_rsp_nxt;

  // lookup signals
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] is_lru;
  logic               found;
  logic               full;
  logic               is_put;
  logic [IDX_W-1:0]   hit_idx, lru_idx, free_idx, tgt_idx;
  logic [RANK_W-1:0]  tgt_rank;
  logic [RANK_W-1:0]  lru_rank;
  logic [CNT_W-1:0]   eff_cap;
  logic               touch_en, ins_en, store_we;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // input register and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      busy_r     <= 1'b1;
    end else begin
      s1_valid_r <= start && !busy_r;
      busy_r     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      s1_req_r <= in_req;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // effective capacity, clamped to 1..ENTRIES
  always_comb begin
    if (capacity_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(capacity_r) > 32'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity_r);
    end
  end

  assign full     = 32'(count_r) >= 32'(eff_cap);
  assign is_put   = (s1_req_r.req_type == REQ_PUT);
  assign lru_rank = RANK_W'(count_r - CNT_W'(1));

  // parallel key compare, lru pick and free slot search
  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == s1_req_r.key);
      is_lru[i] = valid_r[i] && (rank_r[i] == lru_rank);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (is_lru[i]) begin
        lru_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    found = |match;
  end

  // choose the entry this item works on
  always_comb begin
    if (found) begin
      tgt_idx = hit_idx;
    end else if (full) begin
      tgt_idx = lru_idx;
    end else begin
      tgt_idx = free_idx;
    end
    tgt_rank = rank_r[tgt_idx];
    touch_en = s1_valid_r && (found || (is_put && full));
    ins_en   = s1_valid_r && is_put && !found && !full;
    store_we = s1_valid_r && is_put;
  end

  // rank, valid and count update
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (touch_en) begin
        if (IDX_W'(i) == tgt_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < tgt_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end else if (ins_en) begin
        if (IDX_W'(i) == tgt_idx) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // result for this item
  always_comb begin
    out_rsp_nxt.hit = found;
    if (is_put) begin
      out_rsp_nxt.read_value = s1_req_r.value;
    end else if (found) begin
      out_rsp_nxt.read_value = value_r[hit_idx];
    end else begin
      out_rsp_nxt.read_value = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= s1_valid_r;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // key and value stores, result payload
  always_ff @(posedge clk) begin
    if (store_we) begin
      key_r[tgt_idx]   <= s1_req_r.key;
      value_r[tgt_idx] <= s1_req_r.value;
    end
    if (s1_valid_r) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  // checks
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(valid_r)) == 32'(count_r))
    else $error("fill count differs from number of valid entries");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(ENTRIES))
    else $error("fill count above entry total");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key present in more than one valid entry");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_valid_r)
    else $error("registered item gave no result");
endmodule

/* test/lkvc_lru_checker.sv */
// lkvc_lru_checker: watches the cache channels, predicts each result and compares
`timescale 1ns / 1ps
module lkvc_lru_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  lkvc_pkg::lkvc_req_t        in_req,
  input  logic                       out_valid,
  input  lkvc_pkg::lkvc_rsp_t        out_rsp,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         rsp_owed
);
  import lkvc_pkg::*;

  // shadow copy of the store
  logic [KEY_W-1:0]   shadow_key   [ENTRIES];
  logic [VALUE_W-1:0] shadow_value [ENTRIES];
  logic               shadow_valid [ENTRIES];
  logic [RANK_W-1:0]  shadow_rank  [ENTRIES];
  logic [CNT_W-1:0]   shadow_count;
  logic [CAP_W-1:0]   shadow_cap;

  // responses still to come, oldest first
  lkvc_rsp_t due_rsp_q[$];

  // capacity as the block applies it
  function automatic int cap_in_use();
    if (shadow_cap == '0) return 1;
    if (int'(shadow_cap) > ENTRIES) return ENTRIES;
    return int'(shadow_cap);
  endfunction

  // entry becomes most recent, newer valid entries age by one
  function automatic void make_newest(int idx);
    logic [RANK_W-1:0] r;
    r = shadow_rank[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && i != idx && shadow_rank[i] < r)
        shadow_rank[i] = shadow_rank[i] + 1'b1;
    shadow_rank[idx] = '0;
  endfunction

  // lookup plus store update for one get or put
  function automatic lkvc_rsp_t lru_access(lkvc_req_t req);
    lkvc_rsp_t rsp;
    int found;
    int victim;
    int slot;
    found  = -1;
    victim = -1;
    slot   = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && shadow_valid[i] && shadow_key[i] == req.key) found = i;

    if (req.req_type == REQ_GET) begin
      if (found >= 0) begin
        make_newest(found);
        rsp.hit        = 1'b1;
        rsp.read_value = shadow_value[found];
      end else begin
        rsp.hit        = 1'b0;
        rsp.read_value = '0;
      end
      return rsp;
    end

    rsp.hit        = (found >= 0);
    rsp.read_value = req.value;
    if (found >= 0) begin
      shadow_value[found] = req.value;
      make_newest(found);
    end else if (int'(shadow_count) >= cap_in_use()) begin
      // replace the least recent valid entry
      for (int i = 0; i < ENTRIES; i++)
        if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
          victim = i;
      if (victim >= 0) begin
        shadow_key[victim]   = req.key;
        shadow_value[victim] = req.value;
        make_newest(victim);
      end
    end else begin
      // lowest free entry takes the new pair
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !shadow_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i]) shadow_rank[i] = shadow_rank[i] + 1'b1;
        shadow_valid[slot] = 1'b1;
        shadow_key[slot]   = req.key;
        shadow_value[slot] = req.value;
        shadow_rank[slot]  = '0;
        shadow_count       = shadow_count + 1'b1;
      end
    end
    return rsp;
  endfunction

  // sample all channels at each edge
  always @(posedge clk) begin
    lkvc_rsp_t due;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_key[i]   = '0;
        shadow_value[i] = '0;
        shadow_valid[i] = 1'b0;
        shadow_rank[i]  = '0;
      end
      shadow_count = '0;
      shadow_cap   = CAP_RESET;
      due_rsp_q.delete();
    end else begin
      // compare a result before queueing the item taken at this edge
      if (out_valid) begin
        if (due_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: hit=%0b read_value=%08h",
                     out_rsp.hit, out_rsp.read_value);
        end else begin
          due = due_rsp_q.pop_front();
          if (out_rsp.hit !== due.hit || out_rsp.read_value !== due.read_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0b value=%08h, got hit=%0b value=%08h",
                       due.hit, due.read_value, out_rsp.hit, out_rsp.read_value);
          end
        end
      end
      if (cfg_valid && cfg_ready) shadow_cap = cfg_data;
      if (start && !busy) due_rsp_q.push_back(lru_access(in_req));
    end
    rsp_owed = due_rsp_q.size();
  end

endmodule

/* test/lru_key_value_cache_test.sv */
// lru_key_value_cache_test: stimulus, watchdog and verdict for the lru key-value cache
`timescale 1ns / 1ps
module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam int RAND_ITEMS  = 1650;
  localparam int PHASES      = 12;
  localparam int STALL_LIMIT = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  lkvc_req_t          in_req;
  logic               out_valid;
  lkvc_rsp_t          out_rsp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data;
  int                 mismatches;
  int                 rsp_owed;
  int                 stall_cycles;

  logic [KEY_W-1:0]   key_pool[$];

  always #5 clk = ~clk;

  lru_key_value_cache i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lkvc_lru_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .rsp_owed   (rsp_owed)
  );

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one item and hold it until taken
  task automatic send_req(input logic req_type, input logic [KEY_W-1:0] key,
                          input logic [VALUE_W-1:0] value);
    start  <= 1'b1;
    in_req <= '{req_type: req_type, key: key, value: value};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // idle burst with junk on the item bus
  task automatic idle_for(input int cycles);
    start  <= 1'b0;
    in_req <= {1'($urandom_range(1)), KEY_W'($urandom), VALUE_W'($urandom)};
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every result is back, then allow for the pipeline
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (rsp_owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // key mostly from the phase pool so gets and puts hit often
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 80) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 90) return $urandom;
    if (r < 95) return $urandom_range(1) ? '1 : '0;
    return key_pool[$urandom_range(key_pool.size() - 1)] ^ (32'h1 << $urandom_range(31));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  initial begin
    logic [CAP_W-1:0] cap;
    int               cap_used;
    int               idle_pct;
    int               put_pct;
    int               pool_n;
    int               per_phase;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty miss, extreme keys and values, update, fill, eviction
    send_req(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(REQ_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    for (int k = 1; k <= 14; k++) send_req(REQ_PUT, KEY_W'(k), VALUE_W'(k * 3));
    // store is full: the oldest entry goes
    send_req(REQ_PUT, 32'h0000_0100, 32'h5A5A_5A5A);
    send_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);

    // random phases, each with its own capacity and pacing
    per_phase = RAND_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap = CAP_W'(4);   // below the current count
        1:       cap = CAP_W'(0);
        2:       cap = '1;
        3:       cap = CAP_W'(1);
        4:       cap = CAP_W'(16);
        5:       cap = CAP_W'(17);
        default: cap = CAP_W'($urandom_range(31));
      endcase
      drain();
      write_capacity(cap);
      cap_used = (cap == '0) ? 1 : ((int'(cap) > ENTRIES) ? ENTRIES : int'(cap));

      key_pool.delete();
      pool_n = $urandom_range(1, 2 * cap_used + 4);
      for (int p = 0; p < pool_n; p++) begin
        case ($urandom_range(15))
          0:       key_pool.push_back('0);
          1:       key_pool.push_back('1);
          default: key_pool.push_back($urandom);
        endcase
      end

      // no idling in the last part of the run
      if (ph >= PHASES - 2) idle_pct = 0;
      else begin
        case ($urandom_range(3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 30;
          default: idle_pct = 60;
        endcase
      end
      put_pct = $urandom_range(30, 70);

      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(99) < idle_pct) idle_for($urandom_range(1, 16));
        send_req(($urandom_range(99) < put_pct) ? REQ_PUT : REQ_GET,
                 pick_key(), pick_value());
      end
    end

    drain();
    if (mismatches == 0 && rsp_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
